@@ rtl/core/frlc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package frlc_pkg;

    // chunk length in words
    localparam int CHUNK_SIZE = 512;

    // field widths
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 10;
    localparam int CNT_W   = $clog2(CHUNK_SIZE + 1);

    // command codes
    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    // output record queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // stream widths
    localparam int S_TDATA_W = WORD_W;
    localparam int M_TDATA_W = ((COUNT_W + WORD_W + 7) / 8) * 8;

    // one encoded record
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [WORD_W-1:0]  flag;
        logic               last;
    } record_t;

    // up to two records produced by one item, in order
    typedef struct packed {
        logic    first_valid;
        logic    second_valid;
        record_t first;
        record_t second;
    } record_pair_t;

endpackage

`default_nettype wire

@@ rtl/core/frlc_encoder.sv @@
`timescale 1ns / 1ps
`default_nettype none

module frlc_encoder (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          fire,
    input  wire logic                          cmd,
    input  wire logic [frlc_pkg::WORD_W-1:0]   flag_word,
    output frlc_pkg::record_pair_t             records
);

    logic [frlc_pkg::WORD_W-1:0] previous_flag_reg, previous_flag_next;
    logic [frlc_pkg::CNT_W-1:0]  current_run_reg, current_run_next;
    logic [frlc_pkg::CNT_W-1:0]  words_in_chunk_reg, words_in_chunk_next;

    logic                        is_finish;
    logic                        closes_run;
    logic                        chunk_full;
    logic [frlc_pkg::CNT_W-1:0]  run_after;
    frlc_pkg::record_t           rec_closed;
    frlc_pkg::record_t           rec_fill;
    frlc_pkg::record_t           rec_marker;

    // run bookkeeping for the current item
    always_comb begin
        is_finish  = (cmd == frlc_pkg::CMD_FINISH);
        closes_run = (words_in_chunk_reg != '0) && (flag_word != previous_flag_reg);
        chunk_full = (words_in_chunk_reg == frlc_pkg::CNT_W'(frlc_pkg::CHUNK_SIZE - 1));
        run_after  = closes_run ? frlc_pkg::CNT_W'(1)
                                : current_run_reg + frlc_pkg::CNT_W'(1);

        rec_closed.count = frlc_pkg::COUNT_W'(current_run_reg);
        rec_closed.flag  = previous_flag_reg;
        rec_closed.last  = 1'b0;

        rec_fill.count = frlc_pkg::COUNT_W'(run_after);
        rec_fill.flag  = flag_word;
        rec_fill.last  = 1'b1;

        rec_marker.count = frlc_pkg::COUNT_W'(frlc_pkg::CHUNK_SIZE + 1);
        rec_marker.flag  = '0;
        rec_marker.last  = 1'b1;
    end

    // record selection
    always_comb begin
        if (is_finish) begin
            records.first_valid  = fire;
            records.second_valid = fire;
            records.first        = rec_closed;
            records.second       = rec_marker;
        end else begin
            records.first_valid  = fire && (closes_run || chunk_full);
            records.second_valid = fire && closes_run && chunk_full;
            records.first        = closes_run ? rec_closed : rec_fill;
            records.second       = rec_fill;
        end
    end

    // next chunk state
    always_comb begin
        previous_flag_next  = previous_flag_reg;
        current_run_next    = current_run_reg;
        words_in_chunk_next = words_in_chunk_reg;
        if (fire) begin
            if (is_finish || chunk_full) begin
                previous_flag_next  = '1;
                current_run_next    = '0;
                words_in_chunk_next = '0;
            end else begin
                previous_flag_next  = flag_word;
                current_run_next    = run_after;
                words_in_chunk_next = words_in_chunk_reg + frlc_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            previous_flag_reg  <= '1;
            current_run_reg    <= '0;
            words_in_chunk_reg <= '0;
        end else begin
            previous_flag_reg  <= previous_flag_next;
            current_run_reg    <= current_run_next;
            words_in_chunk_reg <= words_in_chunk_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/frlc_out_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module frlc_out_queue (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire frlc_pkg::record_pair_t records,
    output logic                        room,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output frlc_pkg::record_t           out_record
);

    frlc_pkg::record_t              entry_reg [frlc_pkg::QUEUE_DEPTH];
    logic [frlc_pkg::QIDX_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [frlc_pkg::QIDX_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [frlc_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic [frlc_pkg::QIDX_W-1:0]    wr_ptr_second;
    logic [frlc_pkg::QCNT_W-1:0]    push_n;
    logic                           pop;

    // room for the two records one item can make
    assign room       = (count_reg <= frlc_pkg::QCNT_W'(frlc_pkg::QUEUE_DEPTH - 2));
    assign out_valid  = (count_reg != '0);
    assign out_record = entry_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb begin
        pop           = out_valid && out_ready;
        push_n        = frlc_pkg::QCNT_W'(records.first_valid)
                      + frlc_pkg::QCNT_W'(records.second_valid);
        wr_ptr_second = wr_ptr_reg + frlc_pkg::QIDX_W'(1);
        wr_ptr_next   = wr_ptr_reg + frlc_pkg::QIDX_W'(push_n);
        rd_ptr_next   = rd_ptr_reg + frlc_pkg::QIDX_W'(pop);
        count_next    = count_reg + push_n - frlc_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // record storage
    always_ff @(posedge aclk) begin
        if (records.first_valid) begin
            entry_reg[wr_ptr_reg] <= records.first;
        end
        if (records.second_valid) begin
            entry_reg[wr_ptr_second] <= records.second;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/flag_run_length_chunk_encoder.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Run-length encoder for 32-bit action-flag words, cut into chunks of
// frlc_pkg::CHUNK_SIZE words. An append item (s_tuser = 0) with the word on
// s_tdata either extends the current run or closes it, giving a record of
// count and flag; the word that fills a chunk also gives the chunk's final
// run with m_tlast set. A finish item (s_tuser = 1) gives the open run (count
// 0, flag all ones if the chunk is empty) and then an end marker record of
// count CHUNK_SIZE+1 and flag 0 with m_tlast set, and clears the encoder.
// An item is taken into an input register, encoded into a four-entry record
// queue once the queue has room for two records, and its first record shows
// on the m_ side from the queue's registers. The block takes one item per
// cycle as long as each item makes at most one record and m_tready stays
// high; the single m_ port drains one record per cycle while m_tready is high.
module flag_run_length_chunk_encoder (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [frlc_pkg::S_TDATA_W-1:0]    s_tdata,  // [31:0] flag_word
    input  wire logic [0:0]                        s_tuser,  // [0] cmd
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [frlc_pkg::M_TDATA_W-1:0]         m_tdata,  // [9:0] rec_count, [41:10] run_flag
    output logic                                   m_tlast   // last
);

    logic                           in_valid_reg, in_valid_next;
    logic                           in_cmd_reg;
    logic [frlc_pkg::WORD_W-1:0]    in_word_reg;
    logic                           room;
    logic                           fire;
    frlc_pkg::record_pair_t         records;
    frlc_pkg::record_t              out_record;

    // input register
    assign fire     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || fire;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg  <= s_tuser[0];
            in_word_reg <= s_tdata[frlc_pkg::WORD_W-1:0];
        end
    end

    frlc_encoder u_encoder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .cmd       (in_cmd_reg),
        .flag_word (in_word_reg),
        .records   (records)
    );

    frlc_out_queue u_out_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .records    (records),
        .room       (room),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_record (out_record)
    );

    // result packing
    always_comb begin
        m_tdata = '0;
        m_tdata[frlc_pkg::COUNT_W-1:0] = out_record.count;
        m_tdata[frlc_pkg::COUNT_W +: frlc_pkg::WORD_W] = out_record.flag;
        m_tlast = out_record.last;
    end

endmodule

`default_nettype wire

@@ rtl/core/frlc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module frlc_checker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tready,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [frlc_pkg::M_TDATA_W-1:0]    m_tdata,
    input  wire logic                              m_tlast
);

    localparam int PAD_LO = frlc_pkg::COUNT_W + frlc_pkg::WORD_W;

    // reset empties both sides: nothing offered, an item can be taken
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("frlc: not empty after reset");

    // an offered record stays until taken
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("frlc: record withdrawn before taken");

    // end marker always closes a chunk
    a_marker_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (frlc_pkg::CHUNK_SIZE < 1023) && m_tvalid
        && (m_tdata[frlc_pkg::COUNT_W-1:0] == frlc_pkg::COUNT_W'(frlc_pkg::CHUNK_SIZE + 1))
        |-> m_tlast)
        else $error("frlc: end marker without last");

    // pad bits above the flag stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[frlc_pkg::M_TDATA_W-1:PAD_LO] == '0))
        else $error("frlc: nonzero pad bits");

endmodule

bind flag_run_length_chunk_encoder frlc_checker u_frlc_checker (.*);

`default_nettype wire

@@ tb/flag_run_length_chunk_encoder_checker.sv @@
`timescale 1ns / 1ps

module flag_run_length_chunk_encoder_checker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tready,
    input  wire logic [frlc_pkg::S_TDATA_W-1:0]    s_tdata,  // [31:0] flag_word
    input  wire logic [0:0]                        s_tuser,  // [0] cmd
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [frlc_pkg::M_TDATA_W-1:0]    m_tdata,  // [9:0] rec_count, [41:10] run_flag
    input  wire logic                              m_tlast,  // last
    output int                                     mismatch_count,
    output int                                     records_pending
);

    localparam int FLAG_LO = frlc_pkg::COUNT_W;
    localparam int FLAG_HI = frlc_pkg::COUNT_W + frlc_pkg::WORD_W - 1;

    // records the encoder owes, oldest first
    frlc_pkg::record_t records_due[$];

    // encoder state as predicted
    logic [frlc_pkg::WORD_W-1:0] run_word;
    int unsigned                 run_len;
    int unsigned                 chunk_words;

    task automatic clear_chunk();
        run_word    = '1;
        run_len     = 0;
        chunk_words = 0;
    endtask

    task automatic owe_record(input int unsigned count, input logic [frlc_pkg::WORD_W-1:0] flag,
                              input logic last);
        frlc_pkg::record_t rec;
        rec.count = count[frlc_pkg::COUNT_W-1:0];
        rec.flag  = flag;
        rec.last  = last;
        records_due.push_back(rec);
    endtask

    // run-length step for one accepted item
    task automatic encode_item(input logic cmd, input logic [frlc_pkg::WORD_W-1:0] word);
        if (cmd == frlc_pkg::CMD_APPEND) begin
            // a differing word closes the run, except as first word of a chunk
            if (chunk_words != 0 && word != run_word) begin
                owe_record(run_len, run_word, 1'b0);
                run_len = 1;
            end else begin
                run_len++;
            end
            run_word = word;
            chunk_words++;
            // chunk full: final run carries last
            if (chunk_words >= frlc_pkg::CHUNK_SIZE) begin
                owe_record(run_len, run_word, 1'b1);
                clear_chunk();
            end
        end else begin
            // finish: open run, then end marker
            owe_record(run_len, run_word, 1'b0);
            owe_record(frlc_pkg::CHUNK_SIZE + 1, '0, 1'b1);
            clear_chunk();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    initial begin
        mismatch_count  = 0;
        records_pending = 0;
        clear_chunk();
    end

    // watch both channels at the rising edge
    always @(posedge aclk) begin : watch
        frlc_pkg::record_t want;
        if (!aresetn) begin
            records_due.delete();
            clear_chunk();
        end else begin
            // result side first: a record can never come from this edge's item
            if (m_tvalid && m_tready) begin
                if (records_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t ns: extra record, expected none, got %0d %0h %b",
                             $time, m_tdata[frlc_pkg::COUNT_W-1:0], m_tdata[FLAG_HI:FLAG_LO],
                             m_tlast);
                end else begin
                    want = records_due.pop_front();
                    check_field("rec_count", 32'(want.count),
                                32'(m_tdata[frlc_pkg::COUNT_W-1:0]));
                    check_field("run_flag", want.flag, m_tdata[FLAG_HI:FLAG_LO]);
                    check_field("last", 32'(want.last), 32'(m_tlast));
                end
            end
            if (s_tvalid && s_tready)
                encode_item(s_tuser[0], s_tdata[frlc_pkg::WORD_W-1:0]);
        end
        records_pending = records_due.size();
    end

endmodule

@@ tb/flag_run_length_chunk_encoder_test.sv @@
`timescale 1ns / 1ps

module flag_run_length_chunk_encoder_test;

    localparam int PHASE_ITEMS = 60;
    localparam int LONG_WORDS  = frlc_pkg::CHUNK_SIZE;

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [frlc_pkg::S_TDATA_W-1:0]  s_tdata;
    logic [0:0]                      s_tuser;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [frlc_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            m_tlast;

    int mismatch_count;
    int records_pending;

    // idling percentages of the current phase
    int sender_gap_pct = 0;
    int sink_stall_pct = 0;

    // last appended word and a small pool of words for building runs
    logic [31:0] last_sent = 32'hFFFF_FFFF;
    logic [31:0] word_pool [4];

    flag_run_length_chunk_encoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    flag_run_length_chunk_encoder_checker encode_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .mismatch_count  (mismatch_count),
        .records_pending (records_pending)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // receiver stalls at random
    always @(negedge aclk) begin
        m_tready = ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // run limit
    initial begin
        #400000;
        $display("flag_run_length_chunk_encoder regression: fail");
        $finish;
    end

    // offer one item at the falling edge and hold it until taken
    task automatic send_item(input logic cmd, input logic [31:0] word);
        while ($urandom_range(0, 99) < sender_gap_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = word;
        s_tuser  = cmd;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
        if (cmd == frlc_pkg::CMD_APPEND)
            last_sent = word;
    endtask

    // mostly repeats and pool words so that runs form, some full random words
    function automatic logic [31:0] next_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return last_sent;
        else if (pick < 70)
            return word_pool[$urandom_range(0, 3)];
        else if (pick < 80)
            return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
        return $urandom();
    endfunction

    task automatic refill_pool();
        for (int k = 0; k < 4; k++)
            word_pool[k] = $urandom();
    endtask

    // a run of appends, usually closed by a finish
    task automatic run_recording(input int words, input bit close);
        refill_pool();
        for (int k = 0; k < words; k++)
            send_item(frlc_pkg::CMD_APPEND, next_word());
        if (close)
            send_item(frlc_pkg::CMD_FINISH, $urandom());
    endtask

    // one full chunk that fills on a closing word
    task automatic long_recording();
        logic [31:0] word;
        send_item(frlc_pkg::CMD_FINISH, $urandom());
        refill_pool();
        for (int k = 0; k < LONG_WORDS; k++) begin
            if (k < frlc_pkg::CHUNK_SIZE - 1)
                word = next_word();
            else
                word = ~last_sent;
            send_item(frlc_pkg::CMD_APPEND, word);
        end
        // finish straight after a full chunk
        send_item(frlc_pkg::CMD_FINISH, $urandom());
    endtask

    initial begin : stimulus
        int sent;
        int words;
        bit close;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = frlc_pkg::CMD_APPEND;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        // directed: finish on an empty chunk right after reset
        send_item(frlc_pkg::CMD_FINISH, 32'h0000_0000);
        // first word equal to the all-ones reset value, then runs
        send_item(frlc_pkg::CMD_APPEND, 32'hFFFF_FFFF);
        send_item(frlc_pkg::CMD_APPEND, 32'hFFFF_FFFF);
        send_item(frlc_pkg::CMD_APPEND, 32'h0000_0000);
        send_item(frlc_pkg::CMD_APPEND, 32'h0000_0000);
        send_item(frlc_pkg::CMD_APPEND, 32'h0000_0000);
        send_item(frlc_pkg::CMD_APPEND, 32'hA5A5_A5A5);
        send_item(frlc_pkg::CMD_APPEND, 32'h5A5A_5A5A);
        send_item(frlc_pkg::CMD_FINISH, 32'h1234_5678);
        // finish again on the emptied chunk
        send_item(frlc_pkg::CMD_FINISH, 32'hFFFF_FFFF);
        // first word differing from the reset value
        send_item(frlc_pkg::CMD_APPEND, 32'h0000_0000);
        send_item(frlc_pkg::CMD_APPEND, 32'hFFFF_FFFF);
        send_item(frlc_pkg::CMD_FINISH, 32'h0000_0000);
        // single-bit extremes, finish with an ignored all-ones word
        send_item(frlc_pkg::CMD_APPEND, 32'h8000_0000);
        send_item(frlc_pkg::CMD_APPEND, 32'h0000_0001);
        send_item(frlc_pkg::CMD_APPEND, 32'h7FFF_FFFF);
        send_item(frlc_pkg::CMD_APPEND, 32'h7FFF_FFFF);
        send_item(frlc_pkg::CMD_FINISH, 32'hFFFF_FFFF);

        // random recordings over the idling phases
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    sender_gap_pct = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    sender_gap_pct = 53;
                    sink_stall_pct = 0;
                end
                2: begin
                    sender_gap_pct = 0;
                    sink_stall_pct = 53;
                end
                default: begin
                    sender_gap_pct = 8;
                    sink_stall_pct = 8;
                end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                words = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 30);
                close = ($urandom_range(0, 99) < 85);
                run_recording(words, close);
                sent += words + close;
            end
            if (phase == 2)
                long_recording();
        end
        send_item(frlc_pkg::CMD_FINISH, $urandom());

        // drain
        s_tvalid = 1'b0;
        sink_stall_pct = 0;
        while (records_pending != 0)
            @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (mismatch_count == 0 && records_pending == 0)
            $display("flag_run_length_chunk_encoder regression: pass");
        else
            $display("flag_run_length_chunk_encoder regression: fail");
        $finish;
    end

endmodule
